FILE: hw/rtl/wss_pkg.sv
// Shared constants, widths and the control state type for the windowed
// sample statistics block. No dependencies.
`default_nettype none
package wss_pkg;

  localparam int HIST_DEPTH = 120;
  localparam int TIMER_CNT  = 8;

  localparam int DATA_W     = 32;
  localparam int ID_W       = 3;
  localparam int OUT_FILL_W = 7;

  localparam int TID_W  = (TIMER_CNT > 1) ? $clog2(TIMER_CNT) : 1;
  localparam int POS_W  = $clog2(HIST_DEPTH);
  localparam int FILL_W = $clog2(HIST_DEPTH + 1);
  localparam int ADDR_W = $clog2(HIST_DEPTH * TIMER_CNT);
  localparam int SUM_W  = DATA_W + FILL_W;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_START,
    ST_DIV,
    ST_HOLD
  } wss_state_t;

endpackage : wss_pkg
`default_nettype wire

FILE: hw/rtl/windowed_sample_statistics.sv
// Windowed sample statistics: per-timer sample rings with last/avg/min/max.
// A record reads the timer's ring entry by entry, drains the last read, starts the
// divider, runs its steps and loads the output register. No new item is taken until
// the result is loaded, so while a result waits on a stalled output the input stalls.
// A clear resets the write position, fill and call count of every timer.
// Synchronous active-low reset clears timer state, not the RAM.
`default_nettype none
module windowed_sample_statistics
  import wss_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_cmd,
  input  wire logic [ID_W-1:0]       in_timer_id,
  input  wire logic [DATA_W-1:0]     in_duration,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [DATA_W-1:0]          out_last_value,
  output logic [DATA_W-1:0]          out_avg_value,
  output logic [DATA_W-1:0]          out_min_value,
  output logic [DATA_W-1:0]          out_max_value,
  output logic [DATA_W-1:0]          out_call_count,
  output logic [OUT_FILL_W-1:0]      out_window_fill
);

  wss_state_t state_r, state_nxt;

  // per-timer control state
  logic [POS_W-1:0]  wpos_r  [TIMER_CNT];
  logic [FILL_W-1:0] fill_r  [TIMER_CNT];
  logic [DATA_W-1:0] calls_r [TIMER_CNT];

  logic [TID_W-1:0]  tid;
  logic              accept, do_record, do_clear;
  logic [POS_W-1:0]  pos_cur, pos_new;
  logic [FILL_W-1:0] fill_new;
  logic [DATA_W-1:0] calls_new;
  logic [ADDR_W-1:0] base;

  // current item
  logic [ADDR_W-1:0] base_r;
  logic [FILL_W-1:0] ifill_r;
  logic [DATA_W-1:0] icalls_r;
  logic [DATA_W-1:0] sample_r;
  logic [FILL_W-1:0] rd_idx_r, rd_idx_nxt;
  logic              rd_vld_r;
  logic              first_r;
  logic [SUM_W-1:0]  sum_r;
  logic [DATA_W-1:0] min_r, max_r;

  logic              rd_en, div_start, load_out, scan_last;
  logic [DATA_W-1:0] rd_data;
  logic              div_done;
  logic [DATA_W-1:0] quotient;
  logic              out_valid_r;

  assign tid       = in_timer_id[TID_W-1:0];
  assign accept    = in_valid && !in_stall;
  assign do_clear  = accept && (in_cmd == CMD_CLEAR);
  assign do_record = accept && (in_cmd == CMD_RECORD) && (32'(in_timer_id) < TIMER_CNT);

  always_comb begin
    pos_cur   = (32'(wpos_r[tid]) >= HIST_DEPTH) ? '0 : wpos_r[tid];
    pos_new   = (32'(pos_cur) == HIST_DEPTH - 1) ? '0 : POS_W'(pos_cur + 1'b1);
    fill_new  = (32'(fill_r[tid]) < HIST_DEPTH) ? FILL_W'(fill_r[tid] + 1'b1)
                                                : FILL_W'(HIST_DEPTH);
    calls_new = calls_r[tid] + 1'b1;
    base      = ADDR_W'(tid) * ADDR_W'(HIST_DEPTH);
  end

  wss_ring_ram #(
    .DEPTH (HIST_DEPTH * TIMER_CNT),
    .WIDTH (DATA_W),
    .AW    (ADDR_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (do_record),
    .wr_addr (ADDR_W'(base + ADDR_W'(pos_cur))),
    .wr_data (in_duration),
    .rd_en   (rd_en),
    .rd_addr (ADDR_W'(base_r + ADDR_W'(rd_idx_r))),
    .rd_data (rd_data)
  );

  wss_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (ifill_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign scan_last = (rd_idx_r == FILL_W'(ifill_r - 1'b1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (do_record) state_nxt = ST_SCAN;
      ST_SCAN:  if (scan_last) state_nxt = ST_LAST;
      ST_LAST:  state_nxt = ST_START;
      ST_START: state_nxt = ST_DIV;
      ST_DIV:   if (div_done) state_nxt = load_out ? ST_IDLE : ST_HOLD;
      ST_HOLD:  if (load_out) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_stall  = 1'b1;
    rd_en     = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_SCAN:  rd_en = 1'b1;
      ST_LAST:  ;
      ST_START: div_start = 1'b1;
      ST_DIV:   load_out = div_done && (!out_valid_r || !out_stall);
      ST_HOLD:  load_out = !out_valid_r || !out_stall;
      default:  ;
    endcase
  end

  assign rd_idx_nxt = do_record ? '0 : (rd_en ? FILL_W'(rd_idx_r + 1'b1) : rd_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      for (int t = 0; t < TIMER_CNT; t++) begin
        wpos_r[t]  <= '0;
        fill_r[t]  <= '0;
        calls_r[t] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= load_out || (out_valid_r && out_stall);
      rd_vld_r    <= rd_en;
      if (do_clear) begin
        for (int t = 0; t < TIMER_CNT; t++) begin
          wpos_r[t]  <= '0;
          fill_r[t]  <= '0;
          calls_r[t] <= '0;
        end
      end else if (do_record) begin
        wpos_r[tid]  <= pos_new;
        fill_r[tid]  <= fill_new;
        calls_r[tid] <= calls_new;
      end
    end
  end

  // datapath of the current item
  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    if (do_record) begin
      base_r   <= base;
      ifill_r  <= fill_new;
      icalls_r <= calls_new;
      sample_r <= in_duration;
      first_r  <= 1'b1;
    end else if (rd_vld_r) begin
      first_r <= 1'b0;
      if (first_r) begin
        sum_r <= SUM_W'(rd_data);
        min_r <= rd_data;
        max_r <= rd_data;
      end else begin
        sum_r <= sum_r + SUM_W'(rd_data);
        if (rd_data < min_r) min_r <= rd_data;
        if (rd_data > max_r) max_r <= rd_data;
      end
    end
    if (load_out) begin
      out_last_value  <= sample_r;
      out_avg_value   <= quotient;
      out_min_value   <= min_r;
      out_max_value   <= max_r;
      out_call_count  <= icalls_r;
      out_window_fill <= OUT_FILL_W'(ifill_r);
    end
  end

  assign out_valid = out_valid_r;

endmodule : windowed_sample_statistics
`default_nettype wire

FILE: hw/rtl/wss_ring_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Holds the sample rings; no dependencies.
`default_nettype none
module wss_ring_ram #(
  parameter int DEPTH = 960,
  parameter int WIDTH = 32,
  parameter int AW    = 10
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : wss_ring_ram
`default_nettype wire

FILE: hw/rtl/wss_divider.sv
// Restoring divider, one quotient bit a cycle, for the window average.
// Depends on wss_pkg.
`default_nettype none
module wss_divider
  import wss_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [SUM_W-1:0]  dividend,
  input  wire logic [FILL_W-1:0] divisor,
  output logic                   done,
  output logic [DATA_W-1:0]      quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [FILL_W-1:0]    rem_r, rem_nxt;
  logic [SUM_W-1:0]     quot_r, quot_nxt;
  logic [FILL_W-1:0]    dsor_r, dsor_nxt;
  logic [FILL_W:0]      rem_sh;
  logic                 q_bit;

  always_comb begin
    rem_sh   = {rem_r, quot_r[SUM_W-1]};
    q_bit    = (rem_sh >= {1'b0, dsor_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    dsor_nxt = dsor_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quot_nxt = dividend;
      dsor_nxt = divisor;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the top bit drops out
      rem_nxt  = q_bit ? FILL_W'(rem_sh - {1'b0, dsor_r}) : rem_sh[FILL_W-1:0];
      quot_nxt = {quot_r[SUM_W-2:0], q_bit};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    dsor_r <= dsor_nxt;
  end

  assign done     = done_r;
  assign quotient = quot_r[DATA_W-1:0];

endmodule : wss_divider
`default_nettype wire

FILE: tb/testbench.sv
// Testbench for windowed_sample_statistics: record and clear items under random
// sender gaps and receiver stalls, with every result predicted and checked.
// Depends on wss_pkg and the windowed_sample_statistics RTL.
module testbench
  import wss_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DATA_W-1:0]     last_v;
    logic [DATA_W-1:0]     avg_v;
    logic [DATA_W-1:0]     min_v;
    logic [DATA_W-1:0]     max_v;
    logic [DATA_W-1:0]     calls_v;
    logic [OUT_FILL_W-1:0] fill_v;
  } win_stats_t;

  // Per-timer sample windows, mirrored item by item
  class stats_tracker;
    logic [DATA_W-1:0] ring [TIMER_CNT][HIST_DEPTH];
    int unsigned       wr_pos [TIMER_CNT];
    int unsigned       fill [TIMER_CNT];
    logic [DATA_W-1:0] calls [TIMER_CNT];
    win_stats_t        expected_stats [$];
    int                errors, records, clears, checked, deepest, wraps;

    function new();
      foreach (ring[t, i]) ring[t][i] = '0;
      clear_timers();
    endfunction

    function void clear_timers();
      foreach (wr_pos[t]) begin
        wr_pos[t] = 0;
        fill[t]   = 0;
        calls[t]  = '0;
      end
    endfunction

    function void note_item(logic cmd, logic [ID_W-1:0] id, logic [DATA_W-1:0] dur);
      win_stats_t      s;
      longint unsigned total;
      int unsigned     t, i;
      if (cmd == CMD_CLEAR) begin
        clear_timers();
        clears++;
        return;
      end
      t = id;
      if (t >= TIMER_CNT) return;
      records++;
      ring[t][wr_pos[t]] = dur;
      wr_pos[t]++;
      if (wr_pos[t] >= HIST_DEPTH) begin
        wr_pos[t] = 0;
        wraps++;
      end
      if (fill[t] < HIST_DEPTH) fill[t]++;
      if (fill[t] > deepest) deepest = fill[t];
      calls[t] = calls[t] + 1'b1;

      // window is always entries 0 .. fill-1, all written since the last clear
      total   = 0;
      s.min_v = ring[t][0];
      s.max_v = ring[t][0];
      for (i = 0; i < fill[t]; i++) begin
        total += ring[t][i];
        if (ring[t][i] < s.min_v) s.min_v = ring[t][i];
        if (ring[t][i] > s.max_v) s.max_v = ring[t][i];
      end
      s.last_v  = dur;
      s.avg_v   = DATA_W'(total / fill[t]);
      s.calls_v = calls[t];
      s.fill_v  = OUT_FILL_W'(fill[t]);
      expected_stats.push_back(s);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function string field_note(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      return $sformatf("result %0d %s: got %h, want %h", checked, name, got, want);
    endfunction

    task check_result(win_stats_t got);
      win_stats_t want;
      if (expected_stats.size() == 0) begin
        report($sformatf("unexpected result, last %h fill %0d", got.last_v, got.fill_v));
        return;
      end
      want = expected_stats.pop_front();
      checked++;
      if (got.last_v !== want.last_v) report(field_note("last", got.last_v, want.last_v));
      if (got.avg_v !== want.avg_v) report(field_note("avg", got.avg_v, want.avg_v));
      if (got.min_v !== want.min_v) report(field_note("min", got.min_v, want.min_v));
      if (got.max_v !== want.max_v) report(field_note("max", got.max_v, want.max_v));
      if (got.calls_v !== want.calls_v)
        report(field_note("calls", got.calls_v, want.calls_v));
      if (got.fill_v !== want.fill_v)
        report(field_note("fill", DATA_W'(got.fill_v), DATA_W'(want.fill_v)));
    endtask
  endclass

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_cmd      = CMD_RECORD;
  logic [ID_W-1:0]       in_timer_id = '0;
  logic [DATA_W-1:0]     in_duration = '0;
  logic                  out_stall   = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [DATA_W-1:0]     out_last_value, out_avg_value, out_min_value, out_max_value;
  logic [DATA_W-1:0]     out_call_count;
  logic [OUT_FILL_W-1:0] out_window_fill;

  int                    send_idle_pct  = 0;
  int                    recv_stall_pct = 0;
  logic [DATA_W-1:0]     timer_base [TIMER_CNT];
  stats_tracker          tracker;

  windowed_sample_statistics u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_timer_id    (in_timer_id),
    .in_duration    (in_duration),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_last_value (out_last_value),
    .out_avg_value  (out_avg_value),
    .out_min_value  (out_min_value),
    .out_max_value  (out_max_value),
    .out_call_count (out_call_count),
    .out_window_fill(out_window_fill)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_result('{out_last_value, out_avg_value, out_min_value, out_max_value,
                             out_call_count, out_window_fill});
  end

  // valid stays high after acceptance; the next call either idles or reloads it
  task automatic send_item(logic cmd, logic [ID_W-1:0] id, logic [DATA_W-1:0] dur);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_timer_id <= id;
    in_duration <= dur;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_item(cmd, id, dur);
  endtask

  function automatic logic [DATA_W-1:0] pick_duration(logic [DATA_W-1:0] base);
    case ($urandom_range(9))
      0, 1, 2: return $urandom();
      3, 4:    return DATA_W'($urandom_range(32'hFFFF));
      5:       return $urandom_range(1) ? {DATA_W{1'b1}} : {DATA_W{1'b0}};
      6:       return ~DATA_W'($urandom_range(255));
      default: return base + DATA_W'($urandom_range(32'h3FFFF)) - 32'h20000;
    endcase
  endfunction

  // one timer gets most records so its ring fills and wraps; clears are rare
  task automatic run_phase(int gap_pct, int stall_pct, int n);
    int              hot;
    logic [ID_W-1:0] id;
    send_idle_pct  = gap_pct;
    recv_stall_pct = stall_pct;
    hot = $urandom_range(TIMER_CNT - 1);
    foreach (timer_base[t]) timer_base[t] = $urandom();
    repeat (n) begin
      if ($urandom_range(399) == 0) begin
        send_item(CMD_CLEAR, ID_W'($urandom()), $urandom());
      end else begin
        id = ($urandom_range(99) < 60) ? ID_W'(hot) : ID_W'($urandom_range(TIMER_CNT - 1));
        send_item(CMD_RECORD, id, pick_duration(timer_base[id]));
      end
    end
  endtask

  initial begin
    tracker = new();
    send_idle_pct  = 11;
    recv_stall_pct = 85;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // clear on an empty block, then the field extremes
    send_item(CMD_CLEAR, '0, '0);
    send_item(CMD_RECORD, 3'd0, 32'h0000_0000);
    send_item(CMD_RECORD, 3'd0, 32'hFFFF_FFFF);
    send_item(CMD_RECORD, 3'd0, 32'h0001_0000);
    // two maximal samples: the window sum needs more than 32 bits
    send_item(CMD_RECORD, 3'd7, 32'hFFFF_FFFF);
    send_item(CMD_RECORD, 3'd7, 32'hFFFF_FFFF);
    send_item(CMD_RECORD, 3'd1, 32'h5555_5555);
    send_item(CMD_RECORD, 3'd2, 32'hAAAA_AAAA);
    send_item(CMD_RECORD, 3'd3, 32'h0000_0001);
    send_item(CMD_RECORD, 3'd4, 32'h8000_0000);
    send_item(CMD_RECORD, 3'd5, 32'h7FFF_FFFF);
    send_item(CMD_RECORD, 3'd6, 32'h0000_0000);
    send_item(CMD_RECORD, 3'd1, 32'h0000_0003);
    // after a clear the old ring contents must be out of reach
    send_item(CMD_CLEAR, 3'd7, 32'hFFFF_FFFF);
    send_item(CMD_RECORD, 3'd0, 32'h0000_0005);
    send_item(CMD_RECORD, 3'd7, 32'h0000_0003);
    send_item(CMD_RECORD, 3'd7, 32'h0000_0004);

    run_phase(11, 85, 410);
    run_phase(85, 11, 410);
    run_phase(0, 0, 410);
    in_valid <= 1'b0;

    while (tracker.expected_stats.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d records and %0d clears, %0d results checked",
             tracker.records, tracker.clears, tracker.checked);
    $display("deepest window %0d samples, %0d ring wraps", tracker.deepest, tracker.wraps);
    if (tracker.errors == 0) begin
      $display("[windowed_sample_statistics] OK");
    end else begin
      $display("[windowed_sample_statistics] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout: %0d results still outstanding", tracker.expected_stats.size());
    $display("[windowed_sample_statistics] ERROR");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/wss_pkg.sv
hw/rtl/wss_ring_ram.sv
hw/rtl/wss_divider.sv
hw/rtl/windowed_sample_statistics.sv
tb/testbench.sv
